@@ rtl/b2d_pkg.sv @@
// shared constants, types and helpers for the binary to decimal digit converter
// no dependencies; imported by every module of the block
`default_nettype none

package b2d_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int DIGIT_BITS     = 4;
    localparam int QUEUE_DEPTH    = 2;

    // status of the request queue as seen by the back end
    typedef struct packed {
        logic valid;
        logic is_zero;
    } b2d_qstat_t;

    // add-3 correction of one bcd digit before the doubling shift
    function automatic logic [DIGIT_BITS-1:0] dabble_adjust(input logic [DIGIT_BITS-1:0] d);
        logic [DIGIT_BITS-1:0] r;
        r = (d >= DIGIT_BITS'(5)) ? d + DIGIT_BITS'(3) : d;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/b2d_front.sv @@
// front end: accepts requests, flags zero values, holds them in a short queue
// depends on b2d_pkg
`default_nettype none

module b2d_front
    import b2d_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       busy,
    input  wire logic                  q_pop,
    output b2d_qstat_t                 q_stat,
    output logic [VALUE_BITS-1:0]      q_value
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_BITS-1:0] value_mem [QUEUE_DEPTH];
    logic                  zero_mem  [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign busy = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign pop  = q_pop && (count_reg != '0);

    assign q_stat.valid   = (count_reg != '0);
    assign q_stat.is_zero = zero_mem[rd_ptr_reg];
    assign q_value        = value_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_mem[wr_ptr_reg] <= value;
            zero_mem[wr_ptr_reg]  <= (value == '0);
        end
    end

endmodule

`default_nettype wire

@@ rtl/b2d_back.sv @@
// back end: shift-add-3 conversion to bcd, then digit emission msd first
// depends on b2d_pkg; fed by b2d_front
`default_nettype none

module b2d_back
    import b2d_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire b2d_qstat_t            q_stat,
    input  wire logic [VALUE_BITS-1:0] q_value,
    output logic                       q_pop,
    output logic                       valid,
    output logic [DIGIT_BITS-1:0]      digit,
    output logic                       last
);

    localparam int BCD_BITS  = MAX_DIGITS * DIGIT_BITS;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [VALUE_BITS-1:0]   work_reg;
    logic [BCD_BITS-1:0]     bcd_reg;
    logic [BCD_BITS-1:0]     bcd_adj;
    logic                    ovf_reg;
    logic                    lead_reg;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg;
    logic [DIG_CNT_W-1:0]    left_reg;
    logic [DIGIT_BITS-1:0]   top_digit;
    logic                    skip_zero;
    logic                    valid_reg;
    logic [DIGIT_BITS-1:0]   digit_reg;
    logic                    last_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            bcd_adj[k*DIGIT_BITS +: DIGIT_BITS] = dabble_adjust(bcd_reg[k*DIGIT_BITS +: DIGIT_BITS]);
        end
    end

    assign top_digit = bcd_reg[BCD_BITS-1 -: DIGIT_BITS];
    // drop leading zeros unless digits overflowed the store or only one remains
    assign skip_zero = lead_reg && !ovf_reg && (top_digit == '0) && (left_reg != '0);
    assign q_pop     = (state_reg == ST_IDLE) && q_stat.valid;

    assign valid = valid_reg;
    assign digit = digit_reg;
    assign last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            work_reg    <= '0;
            bcd_reg     <= '0;
            ovf_reg     <= 1'b0;
            lead_reg    <= 1'b0;
            bit_cnt_reg <= '0;
            left_reg    <= '0;
            valid_reg   <= 1'b0;
            digit_reg   <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_stat.valid)
                    begin
                        work_reg    <= q_value;
                        bcd_reg     <= '0;
                        ovf_reg     <= 1'b0;
                        lead_reg    <= 1'b1;
                        bit_cnt_reg <= BIT_CNT_W'(VALUE_BITS - 1);
                        left_reg    <= DIG_CNT_W'(MAX_DIGITS - 1);
                        state_reg   <= q_stat.is_zero ? ST_EMIT : ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    bcd_reg  <= {bcd_adj[BCD_BITS-2:0], work_reg[VALUE_BITS-1]};
                    ovf_reg  <= ovf_reg | bcd_adj[BCD_BITS-1];
                    work_reg <= {work_reg[VALUE_BITS-2:0], 1'b0};
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    bcd_reg <= {bcd_reg[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    if (!skip_zero)
                    begin
                        lead_reg  <= 1'b0;
                        valid_reg <= 1'b1;
                        digit_reg <= top_digit;
                        last_reg  <= (left_reg == '0);
                    end
                    if (left_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        left_reg <= left_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/binary_to_decimal_digits.sv @@
// top level of the binary to decimal digit converter
// depends on b2d_pkg, b2d_front and b2d_back
`default_nettype none

// Converts an unsigned binary value into its decimal digits, most significant
// digit first, one digit per valid strobe; the final (least significant) digit
// of a run carries last. Leading zeros are not sent; a value of zero gives the
// single digit 0 with last set. If a value has more than MAX_DIGITS digits,
// only the MAX_DIGITS least significant digits are sent, zeros included.
// A request is taken on a rising edge with start high and busy low; a two-entry
// queue holds requests, so busy rises only when two are waiting behind the one
// in conversion. Digits of a run come on consecutive cycles and cannot be held
// off by the receiver. Each request occupies the back end for a load step, then
// one shift-add-3 step per input bit, then one step per digit position as the
// bcd register is shifted out (leading zeros are dropped in those steps).
// A zero value skips the conversion steps. The shift-add-3 loop over the input
// bits is what sets the rate.

module binary_to_decimal_digits
    import b2d_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       valid,
    output logic [DIGIT_BITS-1:0]      digit,
    output logic                       last
);

    b2d_qstat_t            q_stat;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_pop;

    // request queue and zero detect
    b2d_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .value   (value),
        .busy    (busy),
        .q_pop   (q_pop),
        .q_stat  (q_stat),
        .q_value (q_value)
    );

    // conversion and digit output
    b2d_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_value (q_value),
        .q_pop   (q_pop),
        .valid   (valid),
        .digit   (digit),
        .last    (last)
    );

endmodule

`default_nettype wire

@@ rtl/b2d_checker.sv @@
// port-level checks for the binary to decimal digit converter
// depends on b2d_pkg; bound to binary_to_decimal_digits
`default_nettype none

module b2d_checker
    import b2d_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  valid,
    input wire logic [DIGIT_BITS-1:0] digit,
    input wire logic                  last
);

    // every digit sent is a decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (digit <= DIGIT_BITS'(9)))
        else $error("digit out of decimal range");

    // digits of one run come back to back
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |=> valid)
        else $error("gap inside a digit run");

    // the queue fills only through a request
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // last only marks a sent digit
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> valid)
        else $error("last without valid");

    // the back end reloads after a run ends, so the next cycle is quiet
    a_run_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("digit right after the end of a run");

endmodule

bind binary_to_decimal_digits b2d_checker u_b2d_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .digit (digit),
    .last  (last)
);

`default_nettype wire
